// File: rtl/tacq_pkg.sv
// Shared types and constants for the timed action queue.
package tacq_pkg;

    // Operation codes
    localparam logic [2:0] OP_CHECK     = 3'd0;
    localparam logic [2:0] OP_ADD_REL   = 3'd1;
    localparam logic [2:0] OP_ADD_EXACT = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_ADJUST    = 3'd4;

    localparam int ENTRY_CNT_W = 5;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         action_code;
        logic [31:0]        current_time;
        logic [31:0]        time_offset;
        logic [31:0]        abs_due_time;
        logic signed [31:0] adjustment;
    } cmd_t;

    typedef struct packed {
        logic                   fired;
        logic [7:0]             fired_action;
        logic                   accepted;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  action;
        logic [31:0] due_time;
        logic        is_exact;
    } entry_t;

    // Broadcast from the queue control to every cell
    typedef struct packed {
        logic        do_pop;
        logic        do_insert;
        logic        do_adjust;
        entry_t      new_entry;
        logic [31:0] adj;
    } cell_ctrl_t;

endpackage

// File: rtl/tacq_cell.sv
// One slot of the queue: holds an entry, shifts with its neighbors.
module tacq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  logic [CNT_W-1:0]    count,
    input  tacq_pkg::cell_ctrl_t ctrl,
    input  tacq_pkg::entry_t    left_entry,
    input  tacq_pkg::entry_t    right_entry,
    input  logic                pass_in,
    output logic                pass_out,
    output tacq_pkg::entry_t    entry
);

    tacq_pkg::entry_t entry_reg;
    tacq_pkg::entry_t entry_next;
    logic             occupied;
    logic             passes;

    assign occupied = count > CNT_W'(IDX);
    assign passes   = occupied && (ctrl.new_entry.due_time > entry_reg.due_time);

    always_comb
    begin
        entry_next = entry_reg;
        pass_out   = 1'b0;
        if (ctrl.do_insert)
        begin
            // insert walk: every cell ahead of this one was earlier than the new entry
            pass_out = pass_in && passes;
            if (!pass_in)
            begin
                entry_next = left_entry;
            end
            else if (!passes)
            begin
                entry_next = ctrl.new_entry;
            end
        end
        else if (ctrl.do_pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.do_adjust && occupied && !entry_reg.is_exact)
        begin
            entry_next.due_time = entry_reg.due_time + ctrl.adj;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/timed_action_queue.sv
// Top level of the timed action queue: command register, control and cell chain.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command beat: check, add
//   relative, add exact, clear or adjust. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one response beat per command, in order.
//   The queue is a row of DEPTH cells, head at cell 0. All cells act in the
//   same cycle: insert shifts the tail right and drops the new entry at the
//   first cell whose due time is not earlier; check pops by shifting left;
//   adjust adds to relative entries in place.
//   Each command is first captured in the command register; the cell chain then
//   runs it and loads the response register. A new command is accepted only
//   after the previous one has executed.
//   The insert position ripples through the cell chain, one stage per cell.
//   If the receiver stalls, the response is held and the next command waits
//   in the command register; cmd_ready stays low while that command waits.
//   Reset empties the queue (count to zero), clears rsp_valid and leaves
//   cmd_ready high; entry contents are left as they are and are never read
//   while unoccupied.
module timed_action_queue #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  tacq_pkg::cmd_t   cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tacq_pkg::rsp_t   rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    tacq_pkg::cmd_t       cmd_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    tacq_pkg::rsp_t       rsp_reg;
    tacq_pkg::rsp_t       rsp_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    logic                 exec;
    logic                 full;
    logic                 head_due;
    tacq_pkg::cell_ctrl_t ctrl;
    tacq_pkg::entry_t     cell_q [DEPTH];
    logic [DEPTH:0]       pass;

    assign cmd_ready = !busy_reg;
    assign exec      = busy_reg && (!rsp_valid_reg || rsp_ready);
    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign head_due  = (cnt_reg != '0) && (cell_q[0].due_time <= cmd_reg.current_time);

    // Decode the held command into cell controls and the response
    always_comb
    begin
        ctrl.do_pop                = 1'b0;
        ctrl.do_insert             = 1'b0;
        ctrl.do_adjust             = 1'b0;
        ctrl.new_entry.action      = cmd_reg.action_code;
        ctrl.new_entry.is_exact    = cmd_reg.operation == tacq_pkg::OP_ADD_EXACT;
        ctrl.new_entry.due_time    = ctrl.new_entry.is_exact ? cmd_reg.abs_due_time
                                   : cmd_reg.current_time + cmd_reg.time_offset;
        ctrl.adj                   = $unsigned(cmd_reg.adjustment);
        cnt_next                   = cnt_reg;
        rsp_next.fired             = 1'b0;
        rsp_next.fired_action      = '0;
        rsp_next.accepted          = 1'b1;
        unique case (cmd_reg.operation) inside
            tacq_pkg::OP_CHECK:
            begin
                if (head_due)
                begin
                    ctrl.do_pop           = exec;
                    rsp_next.fired        = 1'b1;
                    rsp_next.fired_action = cell_q[0].action;
                    cnt_next              = cnt_reg - 1'b1;
                end
            end
            tacq_pkg::OP_ADD_REL, tacq_pkg::OP_ADD_EXACT:
            begin
                if (full)
                begin
                    rsp_next.accepted = 1'b0;
                end
                else
                begin
                    ctrl.do_insert = exec;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            tacq_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            tacq_pkg::OP_ADJUST:
            begin
                ctrl.do_adjust = exec;
            end
            default:
            begin
            end
        endcase
        rsp_next.entry_count = tacq_pkg::ENTRY_CNT_W'(cnt_next);
    end

    // Cell chain; the insert walk starts at the head
    assign pass[0] = 1'b1;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tacq_pkg::entry_t left_entry;
        tacq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_mid_r
            assign right_entry = cell_q[i+1];
        end

        tacq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .count       (cnt_reg),
            .ctrl        (ctrl),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .pass_in     (pass[i]),
            .pass_out    (pass[i+1]),
            .entry       (cell_q[i])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd_valid && cmd_ready)
        begin
            busy_next = 1'b1;
        end
        else if (exec)
        begin
            busy_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_exec_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> rsp_valid_reg && !busy_reg)
        else $error("executed command left no response");

    a_no_fire_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.fired |-> rsp_reg.fired_action == 8'd0)
        else $error("action code without fire");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_pop |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not decrement count");

    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        exec && !rsp_next.accepted |-> full && !ctrl.do_insert)
        else $error("add refused while not full");
`endif

endmodule
